### src/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes for the dedup toggle queue: opcodes, result status
// codes and the structs that pass to and between the queue cells.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int SYM_W  = 8;
    localparam int LIVE_W = 7;

    // Command opcodes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_opcode;

    // Result status codes
    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic             valid;
        logic             hole;
        logic [SYM_W-1:0] data;
    } t_cell_link;

    // Broadcast command to every cell
    typedef struct packed {
        logic             pop;
        logic             append;
        logic             remove;
        logic [SYM_W-1:0] symbol;
    } t_cell_cmd;

endpackage

### src/dtq_cmd_if.sv
// ----------------------------------------------------------------------------
// dtq_cmd_if
// Valid/ready channel carrying one queue command transaction.
// ----------------------------------------------------------------------------
interface dtq_cmd_if;
    logic                          valid;
    logic                          ready;
    dtq_pkg::t_opcode              opcode;
    logic [dtq_pkg::SYM_W-1:0]     symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

### src/dtq_res_if.sv
// ----------------------------------------------------------------------------
// dtq_res_if
// Valid/ready channel carrying one queue result transaction.
// ----------------------------------------------------------------------------
interface dtq_res_if;
    logic                          valid;
    logic                          ready;
    dtq_pkg::t_status              status;
    logic [dtq_pkg::SYM_W-1:0]     symbol_out;
    logic [dtq_pkg::LIVE_W-1:0]    live_count;

    modport source (output valid, output status, output symbol_out, output live_count,
                    input ready);
    modport sink   (input valid, input status, input symbol_out, input live_count,
                    output ready);
endinterface

### src/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the queue. Holds a symbol with valid and hole flags, compares
// against the broadcast symbol, and shifts from its right neighbor on pop or
// while a gap left by a removal ripples toward the tail.
// ----------------------------------------------------------------------------
module dtq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtq_pkg::t_cell_cmd  i_cmd,
    input  logic                i_left_valid,
    input  logic                i_left_hole,
    input  dtq_pkg::t_cell_link i_right,
    output dtq_pkg::t_cell_link o_link,
    output logic                o_match
);
    import dtq_pkg::*;

    logic             r_valid, n_valid;
    logic             r_hole,  n_hole;
    logic [SYM_W-1:0] r_data,  n_data;

    // Live, settled entry equal to the broadcast symbol
    assign o_match = r_valid && !r_hole && (r_data == i_cmd.symbol);

    // Next cell contents
    always_comb begin
        n_valid = r_valid;
        n_hole  = r_hole;
        n_data  = r_data;
        priority if (r_hole) begin
            // gap here: pull the right neighbor in, or retire at the tail
            n_hole = 1'b0;
            if (i_right.valid) begin
                n_data = i_right.data;
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_left_hole) begin
            // our entry moves left; the gap moves here
            n_hole = r_valid;
        end else if (i_cmd.pop) begin
            n_valid = i_right.valid;
            n_data  = i_right.data;
        end else if (i_cmd.append && !r_valid && i_left_valid) begin
            n_valid = 1'b1;
            n_data  = i_cmd.symbol;
        end else if (i_cmd.remove && o_match) begin
            n_hole = 1'b1;
        end else begin
            // nothing for this cell: hold
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hole  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hole  <= n_hole;
        end
        r_data <= n_data;
    end

    assign o_link.valid = r_valid;
    assign o_link.hole  = r_hole;
    assign o_link.data  = r_data;

endmodule

### src/dedup_toggle_queue.sv
// ----------------------------------------------------------------------------
// dedup_toggle_queue
// Ordered queue of distinct 8-bit symbols built as a row of CAPACITY cells.
// ----------------------------------------------------------------------------
// Every command yields one result transaction, held in an output register; a
// new command is taken in a cycle where that register is empty or its result
// leaves. Pop, append, insert on full and pop on empty may follow back to
// back while the receiver keeps up.
// Removing a duplicate found at position p (head is 0) leaves a gap there;
// the command channel then stalls while the gap moves one cell per cycle
// toward the tail of the cell row, until it passes the last live entry.
// All cells compare against the symbol in parallel. No clearing pass after
// reset.
// ----------------------------------------------------------------------------
module dedup_toggle_queue #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtq_cmd_if.sink    i_cmd,
    dtq_res_if.source  o_res
);
    import dtq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_cell_link              w_link [CAPACITY+1];
    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_hole;
    t_cell_cmd               w_cmd;

    logic [CW-1:0]           r_count, n_count;
    logic                    r_out_valid;
    t_status                 r_status, n_status;
    logic [SYM_W-1:0]        r_sym_out, n_sym_out;
    logic [LIVE_W-1:0]       r_live;
    logic [CW+LIVE_W-1:0]    w_count_ext;

    logic w_busy, w_accept, w_is_pop, w_empty, w_full, w_found;

    // Handshake
    assign w_busy        = |w_hole;
    assign i_cmd.ready   = !w_busy && (!r_out_valid || o_res.ready);
    assign w_accept      = i_cmd.valid && i_cmd.ready;

    // Decode
    assign w_is_pop = (i_cmd.opcode == OP_POP);
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_found  = |w_match;

    assign w_cmd.pop    = w_accept && w_is_pop && !w_empty;
    assign w_cmd.remove = w_accept && !w_is_pop && w_found;
    assign w_cmd.append = w_accept && !w_is_pop && !w_found && !w_full;
    assign w_cmd.symbol = i_cmd.symbol;

    // Cell row
    assign w_link[CAPACITY] = '0;
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic w_left_valid, w_left_hole;
        if (gi == 0) begin : g_head
            assign w_left_valid = 1'b1;
            assign w_left_hole  = 1'b0;
        end else begin : g_body
            assign w_left_valid = w_link[gi-1].valid;
            assign w_left_hole  = w_link[gi-1].hole;
        end
        dtq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left_valid (w_left_valid),
            .i_left_hole  (w_left_hole),
            .i_right      (w_link[gi+1]),
            .o_link       (w_link[gi]),
            .o_match      (w_match[gi])
        );
        assign w_hole[gi] = w_link[gi].hole;
    end

    // Result and count
    always_comb begin
        n_count   = r_count;
        n_status  = ST_APPENDED;
        n_sym_out = '0;
        priority if (w_is_pop && w_empty) begin
            n_status = ST_EMPTY;
        end else if (w_is_pop) begin
            n_status  = ST_POPPED;
            n_sym_out = w_link[0].data;
            n_count   = r_count - CW'(1);
        end else if (w_found) begin
            n_status  = ST_REMOVED;
            n_sym_out = i_cmd.symbol;
            n_count   = r_count - CW'(1);
        end else if (w_full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_APPENDED;
            n_count  = r_count + CW'(1);
        end
    end

    assign w_count_ext = {{LIVE_W{1'b0}}, n_count};

    // Count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status  <= n_status;
            r_sym_out <= n_sym_out;
            r_live    <= w_count_ext[LIVE_W-1:0];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.symbol_out = r_sym_out;
    assign o_res.live_count = r_live;

endmodule

### src/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks for the dedup toggle queue result channel.
// ----------------------------------------------------------------------------
module dtq_checker #(
    parameter int CAPACITY = 64
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input dtq_pkg::t_status          i_status,
    input logic [dtq_pkg::SYM_W-1:0] i_symbol_out,
    input logic [dtq_pkg::LIVE_W-1:0] i_live_count
);
    import dtq_pkg::*;

    localparam logic [LIVE_W-1:0] CAP_LOW = LIVE_W'(CAPACITY);

    // A stalled result transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_status) && $stable(i_symbol_out) &&
            $stable(i_live_count))
        else $error("result changed while stalled");

    // Results without a symbol report zero
    a_zero_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == ST_APPENDED || i_status == ST_EMPTY ||
                        i_status == ST_FULL) |-> i_symbol_out == '0)
        else $error("nonzero symbol on symbol-less result");

    // Pop on empty leaves an empty queue
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status == ST_EMPTY |-> i_live_count == '0)
        else $error("empty result with nonzero count");

    // Insert on full reports a full queue
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status == ST_FULL |-> i_live_count == CAP_LOW)
        else $error("full result with wrong count");

    // An append always leaves at least one entry
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status == ST_APPENDED && CAPACITY < 128 |->
            i_live_count != '0)
        else $error("append reported an empty queue");

endmodule

bind dedup_toggle_queue dtq_checker #(.CAPACITY(CAPACITY)) u_dtq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_symbol_out (o_res.symbol_out),
    .i_live_count (o_res.live_count)
);

### tb/sv/tb_dedup_toggle_queue.sv
// ----------------------------------------------------------------------------
// tb_dedup_toggle_queue
// Self-checking bench for the dedup toggle queue. A short table of commands
// covers empty pops, appends, duplicate removal at head, middle and tail,
// and pops. Random traffic follows: fill-to-capacity runs with inserts on
// full and duplicates while full, small symbol pools that toggle often,
// drains past empty, and plain noise. Every accepted command goes through a
// behavioral queue model, and each result transaction is checked field by
// field against the oldest expectation. Sender idle and receiver stall rates
// change between phases, and one long receiver hold-off backs the queue up.
// ----------------------------------------------------------------------------
module tb_dedup_toggle_queue;

    import dtq_pkg::*;

    localparam int QCAP = 64;

    // Expected contents of one result transaction
    typedef struct packed {
        t_status           status;
        logic [SYM_W-1:0]  symbol_out;
        logic [LIVE_W-1:0] live_count;
    } t_queue_result;

    // Typed-in expectation for a table row, if it has one
    typedef struct packed {
        bit            typed;
        t_queue_result res;
    } t_row_want;

    // One row of the directed command table
    typedef struct packed {
        t_opcode          op;
        logic [SYM_W-1:0] sym;
        bit               typed;
        t_queue_result    want;
    } t_cmd_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtq_cmd_if cmd_if ();
    dtq_res_if res_if ();

    dedup_toggle_queue #(
        .CAPACITY(QCAP)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    // Model state and scoreboard
    logic [SYM_W-1:0] live_syms[$];
    t_queue_result    expected_results[$];
    t_row_want        row_wants[$];
    int unsigned      err_count = 0;
    int unsigned      sent_count = 0;

    // Traffic shaping knobs
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned res_hold_len = 0;

    always #10 i_clk = ~i_clk;

    // Apply one command to the queue model and return its result
    function automatic t_queue_result apply_queue_cmd(t_opcode op, logic [SYM_W-1:0] sym);
        t_queue_result r;
        int hit;
        r.symbol_out = '0;
        hit = -1;
        if (op == OP_POP) begin
            if (live_syms.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.symbol_out = live_syms.pop_front();
                r.status = ST_POPPED;
            end
        end else begin
            foreach (live_syms[i]) begin
                if (hit < 0 && live_syms[i] == sym) hit = i;
            end
            if (hit >= 0) begin
                r.symbol_out = sym;
                live_syms.delete(hit);
                r.status = ST_REMOVED;
            end else if (live_syms.size() >= QCAP) begin
                r.status = ST_FULL;
            end else begin
                live_syms.push_back(sym);
                r.status = ST_APPENDED;
            end
        end
        r.live_count = LIVE_W'(live_syms.size());
        return r;
    endfunction

    // Random symbol not currently in the queue
    function automatic logic [SYM_W-1:0] absent_symbol();
        logic [SYM_W-1:0] s;
        bit clash;
        do begin
            s = SYM_W'($urandom_range(255));
            clash = 1'b0;
            foreach (live_syms[i]) begin
                if (live_syms[i] == s) clash = 1'b1;
            end
        end while (clash);
        return s;
    endfunction

    // Offer one command transaction; returns at the falling edge after accept
    task automatic send_cmd(t_opcode op, logic [SYM_W-1:0] sym,
                            bit typed = 1'b0, t_queue_result want = '0);
        t_row_want rw;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        rw.typed = typed;
        rw.res = want;
        row_wants.push_back(rw);
        cmd_if.valid = 1'b1;
        cmd_if.opcode = op;
        cmd_if.symbol = sym;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    // Fill to capacity, push on full, toggle duplicates while full, then drain some
    task automatic fill_and_overflow();
        int unsigned keep;
        while (live_syms.size() < QCAP) send_cmd(OP_INSERT, absent_symbol());
        repeat ($urandom_range(4, 1)) send_cmd(OP_INSERT, absent_symbol());
        repeat ($urandom_range(3, 1)) begin
            send_cmd(OP_INSERT, live_syms[$urandom_range(live_syms.size() - 1)]);
            send_cmd(OP_INSERT, absent_symbol());
        end
        keep = $urandom_range(20);
        while (live_syms.size() > keep) send_cmd(OP_POP, SYM_W'($urandom_range(255)));
    endtask

    // Random traffic made of short well-formed episodes plus noise
    task automatic run_random_items(int unsigned n);
        int unsigned target;
        logic [SYM_W-1:0] base;
        target = sent_count + n;
        while (sent_count < target) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    fill_and_overflow();
                end
                3, 4, 5, 6: begin
                    // small symbol pool so inserts hit live entries often
                    base = SYM_W'($urandom_range(255));
                    repeat ($urandom_range(30, 10)) begin
                        if ($urandom_range(3) == 0)
                            send_cmd(OP_POP, SYM_W'($urandom_range(255)));
                        else
                            send_cmd(OP_INSERT, base + SYM_W'($urandom_range(7)));
                    end
                end
                7: begin
                    while (live_syms.size() > 0) send_cmd(OP_POP, SYM_W'($urandom_range(255)));
                    repeat ($urandom_range(3, 1)) send_cmd(OP_POP, SYM_W'($urandom_range(255)));
                end
                default: begin
                    repeat ($urandom_range(20, 5))
                        send_cmd(t_opcode'($urandom_range(1)), SYM_W'($urandom_range(255)));
                end
            endcase
        end
    endtask

    // Result receiver: random stalls plus an occasional long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (res_hold_len != 0) begin
                res_if.ready = 1'b0;
                repeat (res_hold_len) @(negedge i_clk);
                res_hold_len = 0;
            end
            res_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predict on command accept, check on result accept
    always @(posedge i_clk) begin : scoreboard
        t_queue_result pred;
        t_queue_result want;
        t_row_want     rw;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                pred = apply_queue_cmd(cmd_if.opcode, cmd_if.symbol);
                rw = '0;
                if (row_wants.size() != 0) rw = row_wants.pop_front();
                expected_results.push_back(rw.typed ? rw.res : pred);
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no command pending");
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_if.status);
                        err_count++;
                    end
                    if (res_if.symbol_out !== want.symbol_out) begin
                        $error("symbol_out: expected 0x%02h, got 0x%02h",
                               want.symbol_out, res_if.symbol_out);
                        err_count++;
                    end
                    if (res_if.live_count !== want.live_count) begin
                        $error("live_count: expected %0d, got %0d",
                               want.live_count, res_if.live_count);
                        err_count++;
                    end
                end
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        t_cmd_row dir_rows[17];
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = OP_INSERT;
        cmd_if.symbol = '0;

        // op, symbol, typed, {status, symbol_out, live_count}
        dir_rows = '{
            '{OP_POP,    8'h00, 1'b1, '{ST_EMPTY,    8'h00, 7'd0}},
            '{OP_INSERT, 8'h00, 1'b1, '{ST_APPENDED, 8'h00, 7'd1}},
            '{OP_INSERT, 8'hFF, 1'b1, '{ST_APPENDED, 8'h00, 7'd2}},
            '{OP_INSERT, 8'hAA, 1'b1, '{ST_APPENDED, 8'h00, 7'd3}},
            '{OP_INSERT, 8'h55, 1'b1, '{ST_APPENDED, 8'h00, 7'd4}},
            '{OP_INSERT, 8'h00, 1'b1, '{ST_REMOVED,  8'h00, 7'd3}},  // dup at head
            '{OP_INSERT, 8'h55, 1'b1, '{ST_REMOVED,  8'h55, 7'd2}},  // dup at tail
            '{OP_INSERT, 8'h01, 1'b0, '0},
            '{OP_INSERT, 8'h80, 1'b0, '0},
            '{OP_INSERT, 8'hAA, 1'b0, '0},                           // dup in middle
            '{OP_POP,    8'hFF, 1'b0, '0},                           // symbol ignored
            '{OP_POP,    8'h00, 1'b0, '0},
            '{OP_POP,    8'h7E, 1'b0, '0},
            '{OP_POP,    8'h5A, 1'b1, '{ST_EMPTY,    8'h00, 7'd0}},
            '{OP_INSERT, 8'h7F, 1'b1, '{ST_APPENDED, 8'h00, 7'd1}},
            '{OP_INSERT, 8'h7F, 1'b1, '{ST_REMOVED,  8'h7F, 7'd0}},
            '{OP_POP,    8'h00, 1'b1, '{ST_EMPTY,    8'h00, 7'd0}}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) send_cmd(dir_rows[i].op, dir_rows[i].sym,
                                       dir_rows[i].typed, dir_rows[i].want);

        // no idling; long receiver hold-off while the queue fills
        res_hold_len = 300;
        fill_and_overflow();
        run_random_items(290);

        send_idle_pct = 47;
        recv_stall_pct = 0;
        run_random_items(310);

        send_idle_pct = 0;
        recv_stall_pct = 47;
        run_random_items(310);

        send_idle_pct = 15;
        recv_stall_pct = 15;
        run_random_items(310);

        cmd_if.valid = 1'b0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run guard
    initial begin : watchdog
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
src/dtq_pkg.sv
src/dtq_cmd_if.sv
src/dtq_res_if.sv
src/dtq_cell.sv
src/dedup_toggle_queue.sv
src/dtq_checker.sv
tb/sv/tb_dedup_toggle_queue.sv
